// File: design/clt_pkg.sv
// Package for the count to LCD segment RAM block.
// Holds the digit segment patterns, the segment-to-LCD pair map and the word encoder.
// No dependencies.
`default_nettype none

package clt_pkg;

  localparam int COUNT_W = 32;
  localparam int DIGITS = 6;
  localparam int SEGS = 8;
  // The first bit pair is folded into the load; the rest take one step each.
  localparam int STEPS = COUNT_W / 2 - 1;
  localparam int STEP_CNT_W = $clog2(STEPS);

  typedef logic [3:0] bcd_t;
  typedef bcd_t [DIGITS-1:0] digits_t;

  typedef struct packed {
    logic start;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic    full;
    digits_t digits;
  } frame_t;

  typedef struct packed {
    logic       com;
    logic [5:0] line;
  } seg_pair_t;

  // Segment masks per decimal digit: bit 0..6 are A..G, bit 7 is M.
  localparam logic [7:0] DIGIT_MASK [10] = '{
    8'h3F, 8'h06, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h07, 8'hFF, 8'hEF
  };

  // Per display position: A, B, C, D, E, F, G, M as (common, segment line).
  localparam seg_pair_t SEG_MAP [DIGITS][SEGS] = '{
    '{'{1'b1, 6'd40}, '{1'b0, 6'd40}, '{1'b1, 6'd1},  '{1'b1, 6'd0},
      '{1'b0, 6'd0},  '{1'b1, 6'd41}, '{1'b0, 6'd41}, '{1'b0, 6'd1}},
    '{'{1'b1, 6'd26}, '{1'b0, 6'd26}, '{1'b1, 6'd7},  '{1'b1, 6'd2},
      '{1'b0, 6'd2},  '{1'b1, 6'd27}, '{1'b0, 6'd27}, '{1'b0, 6'd7}},
    '{'{1'b1, 6'd24}, '{1'b0, 6'd24}, '{1'b1, 6'd9},  '{1'b1, 6'd8},
      '{1'b0, 6'd8},  '{1'b1, 6'd25}, '{1'b0, 6'd25}, '{1'b0, 6'd9}},
    '{'{1'b1, 6'd20}, '{1'b0, 6'd20}, '{1'b1, 6'd11}, '{1'b1, 6'd10},
      '{1'b0, 6'd10}, '{1'b1, 6'd21}, '{1'b0, 6'd21}, '{1'b0, 6'd11}},
    '{'{1'b1, 6'd18}, '{1'b0, 6'd18}, '{1'b1, 6'd13}, '{1'b1, 6'd12},
      '{1'b0, 6'd12}, '{1'b1, 6'd19}, '{1'b0, 6'd19}, '{1'b0, 6'd13}},
    '{'{1'b1, 6'd17}, '{1'b0, 6'd17}, '{1'b1, 6'd15}, '{1'b1, 6'd14},
      '{1'b0, 6'd14}, '{1'b1, 6'd16}, '{1'b0, 6'd16}, '{1'b0, 6'd15}}
  };

  // Double-dabble correction: add three to a digit of five or more.
  function automatic bcd_t bcd_adjust(input bcd_t d);
    bcd_adjust = (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

  function automatic logic [7:0] digit_mask(input bcd_t d);
    digit_mask = (d <= 4'd9) ? DIGIT_MASK[d] : 8'h00;
  endfunction

  // Builds one LCD RAM word. digits[k] is decimal digit k counted from the
  // least significant one, which sits at display position DIGITS-1-k.
  function automatic logic [31:0] lcd_word(input digits_t digits, input logic [3:0] idx);
    logic [31:0] v;
    logic [7:0]  m;
    seg_pair_t   p;
    v = '0;
    for (int k = 0; k < DIGITS; k++) begin
      m = digit_mask(digits[k]);
      for (int s = 0; s < SEGS; s++) begin
        p = SEG_MAP[DIGITS-1-k][s];
        if (m[s] && ({2'b00, p.com, p.line[5]} == idx)) begin
          v[p.line[4:0]] = 1'b1;
        end
      end
    end
    lcd_word = v;
  endfunction

endpackage

`default_nettype wire

// File: design/clt_if.sv
// Channel interfaces of the count to LCD segment RAM block.
// Depends on clt_pkg for the count width.
`default_nettype none

interface clt_count_if;
  import clt_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;
  modport source (output valid, output count_value, input ready);
  modport sink (input valid, input count_value, output ready);
endinterface

interface clt_word_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [31:0] word_value;
  logic        last_word;
  modport source (output valid, output word_index, output word_value, output last_word,
                  input ready);
  modport sink (input valid, input word_index, input word_value, input last_word,
                output ready);
endinterface

`default_nettype wire

// File: design/clt_bcd_cell.sv
// One BCD digit cell of the binary-to-decimal chain: two shift-and-adjust steps per cycle.
// Depends on clt_pkg.
`default_nettype none

module clt_bcd_cell
  import clt_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  bcd_t      start_digit,
  input  logic [1:0] cin,
  output logic [1:0] cout,
  output bcd_t      digit
);

  bcd_t digit_reg;
  bcd_t a1;
  bcd_t d1;
  bcd_t a2;
  bcd_t digit_next;

  // The carry of each step depends only on the digit before that step, so no
  // carry ripples along the whole chain.
  always_comb begin
    a1 = bcd_adjust(digit_reg);
    d1 = {a1[2:0], cin[1]};
    a2 = bcd_adjust(d1);
    digit_next = {a2[2:0], cin[0]};
    cout = {a1[3], a2[3]};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      digit_reg <= start_digit;
    end else if (ctl.step) begin
      digit_reg <= digit_next;
    end
  end

  assign digit = digit_reg;

endmodule

`default_nettype wire

// File: design/clt_bcd_conv.sv
// Input stage: a chain of BCD cells fed two count bits per cycle from a shift register.
// Depends on clt_pkg, clt_if and clt_bcd_cell.
`default_nettype none

module clt_bcd_conv
  import clt_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  clt_count_if.sink      count_in,
  input  logic           take,
  output frame_t         frame
);

  logic                  busy;
  logic                  full;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [COUNT_W-3:0]    shreg;
  logic                  accept;
  cell_ctl_t             ctl;
  logic [1:0]            carry [DIGITS-1];
  digits_t               digits;

  assign count_in.ready = !busy && (!full || take);
  assign accept = count_in.valid && count_in.ready;
  assign ctl = '{start: accept, step: busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      full <= 1'b0;
      step_cnt <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      full <= 1'b0;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == STEP_CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        full <= 1'b1;
      end
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= count_in.count_value[COUNT_W-3:0];
    end else if (busy) begin
      shreg <= {shreg[COUNT_W-5:0], 2'b00};
    end
  end

  // Cell 0 holds the ones digit. Carries out of the top cell fall away, which
  // leaves the count modulo one million.
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_low
      clt_bcd_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .start_digit ({2'b00, count_in.count_value[COUNT_W-1:COUNT_W-2]}),
        .cin         (shreg[COUNT_W-3:COUNT_W-4]),
        .cout        (carry[k]),
        .digit       (digits[k])
      );
    end else if (k == DIGITS - 1) begin : g_top
      clt_bcd_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .start_digit (4'd0),
        .cin         (carry[k-1]),
        .cout        (),
        .digit       (digits[k])
      );
    end else begin : g_mid
      clt_bcd_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .start_digit (4'd0),
        .cin         (carry[k-1]),
        .cout        (carry[k]),
        .digit       (digits[k])
      );
    end
  end

  assign frame = '{full: full, digits: digits};

endmodule

`default_nettype wire

// File: design/clt_emitter.sv
// Output stage: holds one frame of digits, emits LCD RAM words one per cycle while ready.
// Depends on clt_pkg and clt_if.
`default_nettype none

module clt_emitter
  import clt_pkg::*;
#(
  parameter int RAM_WORDS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  frame_t     frame,
  output logic       take,
  clt_word_if.source word_out
);

  digits_t    digits_reg;
  logic [3:0] idx;
  logic       valid;
  logic       last;
  logic       fire;

  assign last = (idx == 4'(RAM_WORDS - 1));
  assign fire = valid && word_out.ready;
  assign take = frame.full && (!valid || (fire && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= '0;
    end else if (take) begin
      valid <= 1'b1;
      idx <= '0;
      digits_reg <= frame.digits;
    end else if (fire) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign word_out.valid = valid;
  assign word_out.word_index = idx;
  assign word_out.word_value = lcd_word(digits_reg, idx);
  assign word_out.last_word = last;

endmodule

`default_nettype wire

// File: design/count_to_lcd_segment_ram_core.sv
// Count to LCD segment RAM: top level.
// Depends on clt_pkg, clt_if, clt_bcd_conv and clt_emitter.
//
// Usage: count_in carries one item per count (count_value, 32 bits unsigned).
// For each item the block emits a frame of RAM_WORDS items on word_out, one
// per LCD RAM word, with word_index counting 0 .. RAM_WORDS-1, word_value the
// segment bits of that word, and last_word high on the final word, which the
// receiver treats as the commit and update request.
// The count is converted to decimal by a chain of six BCD digit cells that
// take two count bits per cycle: the first bit pair is folded in at
// acceptance and 15 steps follow. The emitter then loads the finished frame
// into its frame register once the previous frame is out.
// The conversion chain accepts no new count while it converts. The emitter
// holds the finished frame, so the next count converts while the previous
// frame is still sent.
// When the receiver stalls, the current word holds; once a converted frame
// waits for the emitter, count_in.ready drops until the emitter takes it.
// Reset (rst, synchronous) empties both stages; no word is valid after it.
`default_nettype none

module count_to_lcd_segment_ram_core
  import clt_pkg::*;
#(
  parameter int RAM_WORDS = 16
) (
  input  logic       clk,
  input  logic       rst,
  clt_count_if.sink  count_in,
  clt_word_if.source word_out
);

  frame_t frame;
  logic   take;

  // Decimal conversion: shift register plus the chain of digit cells.
  clt_bcd_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .count_in (count_in),
    .take     (take),
    .frame    (frame)
  );

  // Word emission: frame register, word counter and segment encoding.
  clt_emitter #(
    .RAM_WORDS (RAM_WORDS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .take     (take),
    .word_out (word_out)
  );

endmodule

`default_nettype wire

// File: design/clt_checker.sv
// Port-level checks for the count to LCD segment RAM block, with the bind
// that attaches them to the top level. No package dependency.
`default_nettype none

module clt_checker #(
  parameter int RAM_WORDS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  word_index,
  input logic [31:0] word_value,
  input logic        last_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index) &&
      $stable(word_value) && $stable(last_word))
    else $error("stalled word changed");

  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == 4'($past(word_index) + 4'd1)))
    else $error("word index did not advance");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word ##1 out_valid |-> word_index == 4'd0)
    else $error("frame did not restart at word zero");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_word == (word_index == 4'(RAM_WORDS - 1)))
    else $error("last word flag misplaced");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("word valid after reset");

endmodule

bind count_to_lcd_segment_ram_core clt_checker #(
  .RAM_WORDS (RAM_WORDS)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (word_out.valid),
  .out_ready  (word_out.ready),
  .word_index (word_out.word_index),
  .word_value (word_out.word_value),
  .last_word  (word_out.last_word)
);

`default_nettype wire

// File: tb/tb_count_to_lcd_segment_ram_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for count_to_lcd_segment_ram_core.
// Depends on clt_pkg, clt_if and count_to_lcd_segment_ram_core with its submodules.
// Drives counts, predicts every LCD RAM word of each frame and checks them in order.

module tb_count_to_lcd_segment_ram_core;
  import clt_pkg::*;

  localparam int RAM_WORDS = 16;
  localparam int N_DIRECTED = 19;
  // The receiver's long stall, long enough for the block to fill and block its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted item before the run is declared hung. The slowest
  // correct stretch is the long receiver stall plus one frame at a heavy stall rate;
  // this limit allows several times that.
  localparam int QUIET_LIMIT = 2000;
  // Wait allowed for a frame to be converted and for all of its words to leave.
  localparam int FRAME_LATENCY = 32;

  typedef logic [RAM_WORDS-1:0][31:0] lcd_frame_t;

  typedef struct packed {
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        last_word;
  } lcd_word_t;

  // One row of the directed table. Where the display is easy to read by eye, the
  // four low words are typed in and the rest of the frame must be zero.
  typedef struct packed {
    logic [31:0]       count;
    logic              typed;
    logic [3:0][31:0]  low_words;
  } count_row_t;

  // Segments lit per decimal digit: bit 0..6 are A..G, bit 7 is M.
  localparam logic [7:0] DIGIT_LIT [10] = '{
    8'h3F, 8'h06, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h07, 8'hFF, 8'hEF
  };

  // Per display position, for A, B, C, D, E, F, G, M: {common, segment line}.
  localparam logic [6:0] LCD_PAIR [6][8] = '{
    '{{1'b1, 6'd40}, {1'b0, 6'd40}, {1'b1, 6'd1},  {1'b1, 6'd0},
      {1'b0, 6'd0},  {1'b1, 6'd41}, {1'b0, 6'd41}, {1'b0, 6'd1}},
    '{{1'b1, 6'd26}, {1'b0, 6'd26}, {1'b1, 6'd7},  {1'b1, 6'd2},
      {1'b0, 6'd2},  {1'b1, 6'd27}, {1'b0, 6'd27}, {1'b0, 6'd7}},
    '{{1'b1, 6'd24}, {1'b0, 6'd24}, {1'b1, 6'd9},  {1'b1, 6'd8},
      {1'b0, 6'd8},  {1'b1, 6'd25}, {1'b0, 6'd25}, {1'b0, 6'd9}},
    '{{1'b1, 6'd20}, {1'b0, 6'd20}, {1'b1, 6'd11}, {1'b1, 6'd10},
      {1'b0, 6'd10}, {1'b1, 6'd21}, {1'b0, 6'd21}, {1'b0, 6'd11}},
    '{{1'b1, 6'd18}, {1'b0, 6'd18}, {1'b1, 6'd13}, {1'b1, 6'd12},
      {1'b0, 6'd12}, {1'b1, 6'd19}, {1'b0, 6'd19}, {1'b0, 6'd13}},
    '{{1'b1, 6'd17}, {1'b0, 6'd17}, {1'b1, 6'd15}, {1'b1, 6'd14},
      {1'b0, 6'd14}, {1'b1, 6'd16}, {1'b0, 6'd16}, {1'b0, 6'd15}}
  };

  // "000000": every position lights A..F. The common 1 segments (A, C, D, F) cover
  // all common 1 lines below 32 in word 2 and lines 40/41 in word 3; B and E go to
  // words 0 and 1.
  localparam logic [3:0][31:0] ZEROS_SHOWN = {
    32'h0000_0300, 32'h0F3F_FF87, 32'h0000_0100, 32'h0516_5505
  };
  // "888888": every segment lights, so both commons carry their full line sets.
  localparam logic [3:0][31:0] EIGHTS_SHOWN = {
    32'h0000_0300, 32'h0F3F_FF87, 32'h0000_0300, 32'h0F3F_FF87
  };

  // Directed part: the all-zero and all-eight displays, values that wrap at a million,
  // the 32-bit extremes, every digit at several positions and alternating bits.
  localparam count_row_t DIRECTED [N_DIRECTED] = '{
    '{32'd0,          1'b1, ZEROS_SHOWN},
    '{32'd1000000,    1'b1, ZEROS_SHOWN},
    '{32'd888888,     1'b1, EIGHTS_SHOWN},
    '{32'd4294888888, 1'b1, EIGHTS_SHOWN},
    '{32'd999999,     1'b0, '0},
    '{32'hFFFF_FFFF,  1'b0, '0},
    '{32'd123456,     1'b0, '0},
    '{32'd789012,     1'b0, '0},
    '{32'd345678,     1'b0, '0},
    '{32'd901234,     1'b0, '0},
    '{32'd567890,     1'b0, '0},
    '{32'd1,          1'b0, '0},
    '{32'd10,         1'b0, '0},
    '{32'd100000,     1'b0, '0},
    '{32'd111111,     1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  clt_count_if count_in ();
  clt_word_if  word_out ();

  count_to_lcd_segment_ram_core #(
    .RAM_WORDS(RAM_WORDS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .count_in(count_in),
    .word_out(word_out)
  );

  always #1 clk = ~clk;

  // Words still owed by the block, oldest first.
  lcd_word_t pending_words [$];
  lcd_word_t oldest_word;

  int send_idle_pct = 23;
  int recv_idle_pct = 66;
  bit hold_words_req = 1'b0;

  int errors = 0;
  int counts_sent = 0;
  int words_checked = 0;
  int quiet_cycles = 0;

  // Works out the whole LCD RAM frame for one count. The six low decimal digits
  // are peeled off from the least significant end, which sits at position 5.
  function automatic lcd_frame_t segment_frame(input logic [31:0] count);
    lcd_frame_t  frame;
    logic [31:0] rest;
    logic [3:0]  digit;
    logic [6:0]  pair;
    int unsigned word_sel;
    frame = '0;
    rest = count % 32'd1000000;
    for (int pos = 5; pos >= 0; pos--) begin
      digit = 4'(rest % 32'd10);
      rest = rest / 32'd10;
      for (int s = 0; s < 8; s++) begin
        if (DIGIT_LIT[digit][s]) begin
          pair = LCD_PAIR[pos][s];
          // Word is common*2 plus bit 5 of the segment line.
          word_sel = {pair[6], pair[5]};
          if (word_sel < RAM_WORDS) begin
            frame[word_sel][pair[4:0]] = 1'b1;
          end
        end
      end
    end
    return frame;
  endfunction

  // Random counts: a mix of full 32-bit values (every input bit toggles), values
  // inside the displayed range, values at the top of the 32-bit range, and values
  // just around a multiple of a million where the display wraps.
  function automatic logic [31:0] pick_count();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(999999));
      2: return 32'hFFFF_FFFF - 32'($urandom_range(15));
      default: return 32'($urandom_range(4293)) * 32'd1000000 + 32'($urandom_range(999990, 1000009));
    endcase
  endfunction

  // Offers one count, idling first as the current profile asks, and once it is
  // taken queues the sixteen words it must produce. valid is left high on return,
  // so the next call either keeps it high or lowers it, never both in one step.
  task automatic send_count(input logic [31:0] count, input logic typed,
                            input logic [3:0][31:0] low_words);
    lcd_frame_t frame;
    while ($urandom_range(99) < send_idle_pct) begin
      count_in.valid <= 1'b0;
      count_in.count_value <= $urandom;
      @(posedge clk);
    end
    count_in.valid <= 1'b1;
    count_in.count_value <= count;
    do @(posedge clk); while (count_in.ready !== 1'b1);
    counts_sent++;
    if (typed) begin
      frame = '0;
      frame[3:0] = low_words;
    end else begin
      frame = segment_frame(count);
    end
    for (int i = 0; i < RAM_WORDS; i++) begin
      pending_words.push_back('{word_index: 4'(i), word_value: frame[i],
                                last_word: (i == RAM_WORDS - 1)});
    end
  endtask

  // Stops offering and waits until every queued word has come out.
  task automatic wait_frames_done();
    count_in.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Receiver: takes words at the current stall rate. When the sender asks for it,
  // it refuses words for a long stretch so that a frame is stuck in the emitter,
  // the next count finishes converting behind it, and the input has to stall.
  initial begin
    word_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_words_req) begin
        word_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_words_req = 1'b0;
      end else begin
        word_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Checker: each accepted word must match the oldest queued word field by field.
  always @(posedge clk) begin
    if (!rst && word_out.valid === 1'b1 && word_out.ready === 1'b1) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: index %0d value %h last %b", $time,
                 word_out.word_index, word_out.word_value, word_out.last_word);
      end else begin
        oldest_word = pending_words.pop_front();
        if (word_out.word_index !== oldest_word.word_index) begin
          errors++;
          $display("%0t: word_index expected %0d actual %0d", $time,
                   oldest_word.word_index, word_out.word_index);
        end
        if (word_out.word_value !== oldest_word.word_value) begin
          errors++;
          $display("%0t: word_value of word %0d expected %h actual %h", $time,
                   oldest_word.word_index, oldest_word.word_value, word_out.word_value);
        end
        if (word_out.last_word !== oldest_word.last_word) begin
          errors++;
          $display("%0t: last_word of word %0d expected %b actual %b", $time,
                   oldest_word.word_index, oldest_word.last_word, word_out.last_word);
        end
      end
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk) begin
    if ((count_in.valid === 1'b1 && count_in.ready === 1'b1) ||
        (word_out.valid === 1'b1 && word_out.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d words outstanding", $time,
               QUIET_LIMIT, pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus. Three idling profiles run in turn: a slow receiver, then a slow
  // sender, then both at full rate. The last profile also holds the receiver off
  // for a long stretch while counts keep coming, which fills both stages.
  initial begin
    count_in.valid <= 1'b0;
    count_in.count_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Profile 1: sender idles now and then, receiver mostly stalls.
    send_idle_pct = 23;
    recv_idle_pct = 66;
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_count(DIRECTED[r].count, DIRECTED[r].typed, DIRECTED[r].low_words);
    end
    for (int n = 0; n < 45; n++) begin
      send_count(pick_count(), 1'b0, '0);
    end
    // The sender pauses here until the block has emptied.
    wait_frames_done();

    // Profile 2: the other way round.
    send_idle_pct = 66;
    recv_idle_pct = 23;
    for (int n = 0; n < 50; n++) begin
      send_count(pick_count(), 1'b0, '0);
    end
    wait_frames_done();

    // Profile 3: no idling, with one long receiver stall at the start.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_words_req = 1'b1;
    for (int n = 0; n < 53; n++) begin
      send_count(pick_count(), 1'b0, '0);
    end
    wait_frames_done();

    // Give a misbehaving block time to put out words nobody asked for.
    repeat (FRAME_LATENCY) @(posedge clk);

    $display("Sent %0d counts (%0d directed) and checked %0d LCD RAM words", counts_sent,
             N_DIRECTED, words_checked);
    $display("under slow-receiver, slow-sender, full-rate and long-stall conditions.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
